@@ src/overwrite_ring_buffer_with_average_defines.svh @@
// Assertion helpers used by the checker file
`ifndef OVERWRITE_RING_BUFFER_WITH_AVERAGE_DEFINES_SVH
`define OVERWRITE_RING_BUFFER_WITH_AVERAGE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ORBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ORBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/orba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package orba_pkg;

    localparam int DEFAULT_MAX_DEPTH = 128;
    localparam int RESET_DEPTH       = 128;
    localparam int PERCENT_SCALE     = 100;

    localparam int SAMPLE_W = 32;
    localparam int AGE_W    = 8;
    localparam int DEPTH_W  = 8;
    localparam int AVG_W    = 16;
    localparam int FILL_W   = 8;
    localparam int PCT_W    = 7;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

endpackage

`default_nettype wire

@@ src/overwrite_ring_buffer_with_average.sv @@
// Channel   Signals                                  Direction   Flow control
// -------   --------------------------------------   ---------   --------------------------
// in        mode, sample, age                        in          in_valid / in_stall (out)
// out       data, average, fill_count, used_percent, out         out_valid / out_stall (in)
//           is_full, is_empty, fault
// cfg       cfg_data (depth_in_use)                  in          cfg_valid / cfg_ready (out)
//
// One transaction at a time. Each passes through the slot memory access where its mode needs it, a setup step,
// SUM_W = 32 + clog2(MAX_DEPTH+1) shift-subtract steps for the average (skipped when empty),
// CNT_W + 7 steps for the percent, and the hand-over.
// A single shared restoring divider computes both the average and the percent.
// Reset empties the ring; slot contents stay undefined until written.
// A held output stalls only the final hand-over; the next input waits for the block to idle.

`timescale 1ns / 1ps
`default_nettype none

module overwrite_ring_buffer_with_average #(
    parameter int MAX_DEPTH = orba_pkg::DEFAULT_MAX_DEPTH
) (
    input  wire                                  clk,
    input  wire                                  rst_n,

    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [orba_pkg::DEPTH_W-1:0]         cfg_data,

    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  orba_pkg::mode_t                      mode,
    input  wire  signed [orba_pkg::SAMPLE_W-1:0] sample,
    input  wire  [orba_pkg::AGE_W-1:0]           age,

    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic signed [orba_pkg::SAMPLE_W-1:0] data,
    output logic [orba_pkg::AVG_W-1:0]           average,
    output logic [orba_pkg::FILL_W-1:0]         fill_count,
    output logic [orba_pkg::PCT_W-1:0]          used_percent,
    output logic                                 is_full,
    output logic                                 is_empty,
    output logic                                 fault
);

    import orba_pkg::*;

    localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W   = $clog2(MAX_DEPTH);
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int PNUM_W  = CNT_W + $clog2(PERCENT_SCALE + 1);
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int ADDR9_W = DEPTH_W + 1;
    localparam int CAP_RST = (RESET_DEPTH > MAX_DEPTH) ? MAX_DEPTH : RESET_DEPTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAKE,
        ST_PUSH,
        ST_READ,
        ST_STATUS,
        ST_DIV_AVG,
        ST_DIV_PCT,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           cap_reg;
    logic [IDX_W-1:0]           oldest_reg;
    logic [IDX_W-1:0]           newest_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    mode_t                      mode_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SAMPLE_W-1:0]        res_data_reg;
    logic                       res_fault_reg;
    logic [AVG_W-1:0]           res_avg_reg;

    logic [SUM_W-1:0]           dvd_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic [AVG_W-1:0]           quo_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       neg_reg;

    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic [AVG_W-1:0]           out_avg_reg;
    logic [FILL_W-1:0]          out_fill_reg;
    logic [PCT_W-1:0]           out_pct_reg;
    logic                       out_full_reg;
    logic                       out_empty_reg;
    logic                       out_fault_reg;

    logic [SAMPLE_W-1:0]        slot_mem [MAX_DEPTH];
    logic [SAMPLE_W-1:0]        rd_data_reg;

    logic                       cfg_fire;
    logic                       in_fire;
    logic                       out_load;
    logic [CNT_W-1:0]           cap_cfg;
    logic                       ring_full;
    logic                       ring_empty;
    logic                       take_now;
    logic                       read_hit;
    logic [ADDR9_W-1:0]         read_pos;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;
    logic [IDX_W-1:0]           oldest_inc;
    logic [IDX_W-1:0]           newest_inc;
    logic signed [SUM_W-1:0]    rd_ext;
    logic signed [SUM_W-1:0]    sample_ext;
    logic [SUM_W-1:0]           sum_mag;
    logic [PNUM_W-1:0]          pct_num;
    logic [CNT_W-1:0]           divisor;
    logic [CNT_W:0]             rem_shift;
    logic                       quo_bit;
    logic [CNT_W-1:0]           rem_new;
    logic [AVG_W-1:0]           quo_new;
    logic [AVG_W-1:0]           avg_signed;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) | cfg_valid;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_fire   = in_valid & ~in_stall;
    assign out_load  = (state_reg == ST_DONE) & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_cfg = CNT_W'(1);
        end
        else if (cfg_data > DEPTH_W'(MAX_DEPTH))
        begin
            cap_cfg = CNT_W'(MAX_DEPTH);
        end
        else
        begin
            cap_cfg = CNT_W'(cfg_data);
        end
    end

    assign ring_full  = (count_reg == cap_reg);
    assign ring_empty = (count_reg == '0);
    assign take_now   = ((mode == MODE_PUSH) & ring_full) | ((mode == MODE_POP) & ~ring_empty);
    assign read_hit   = (mode == MODE_READ) & (age < DEPTH_W'(count_reg));

    assign read_pos = ADDR9_W'(newest_reg)
                    + ((ADDR9_W'(newest_reg) >= ADDR9_W'(age)) ? '0 : ADDR9_W'(cap_reg))
                    - ADDR9_W'(age);

    assign rd_en   = in_fire & (take_now | read_hit);
    assign rd_addr = take_now ? oldest_reg : IDX_W'(read_pos);

    assign oldest_inc = ((CNT_W'(oldest_reg) + CNT_W'(1)) == cap_reg) ? '0
                      : oldest_reg + IDX_W'(1);
    assign newest_inc = ((CNT_W'(newest_reg) + CNT_W'(1)) == cap_reg) ? '0
                      : newest_reg + IDX_W'(1);
    assign wr_en      = (state_reg == ST_PUSH);

    assign rd_ext     = {{(SUM_W - SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
    assign sample_ext = {{(SUM_W - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign pct_num    = PNUM_W'(count_reg) * PNUM_W'(PERCENT_SCALE);

    assign divisor    = (state_reg == ST_DIV_AVG) ? count_reg : cap_reg;
    assign rem_shift  = {rem_reg, dvd_reg[SUM_W-1]};
    assign quo_bit    = (rem_shift >= {1'b0, divisor});
    assign rem_new    = quo_bit ? CNT_W'(rem_shift - {1'b0, divisor}) : CNT_W'(rem_shift);
    assign quo_new    = {quo_reg[AVG_W-2:0], quo_bit};
    assign avg_signed = neg_reg ? AVG_W'(-quo_new) : quo_new;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[newest_inc] <= sample_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CNT_W'(CAP_RST);
            oldest_reg    <= '0;
            newest_reg    <= IDX_W'(CAP_RST - 1);
            count_reg     <= '0;
            sum_reg       <= '0;
            mode_reg      <= MODE_QUERY;
            sample_reg    <= '0;
            res_data_reg  <= '0;
            res_fault_reg <= 1'b0;
            res_avg_reg   <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_avg_reg   <= '0;
            out_fill_reg  <= '0;
            out_pct_reg   <= '0;
            out_full_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
            out_fault_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_data_reg;
                out_avg_reg   <= res_avg_reg;
                out_fill_reg  <= FILL_W'(count_reg);
                out_pct_reg   <= quo_reg[PCT_W-1:0];
                out_full_reg  <= ring_full;
                out_empty_reg <= ring_empty;
                out_fault_reg <= res_fault_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        cap_reg    <= cap_cfg;
                        oldest_reg <= '0;
                        newest_reg <= IDX_W'(cap_cfg - CNT_W'(1));
                        count_reg  <= '0;
                        sum_reg    <= '0;
                    end
                    else if (in_fire)
                    begin
                        mode_reg      <= mode;
                        sample_reg    <= sample;
                        res_data_reg  <= '0;
                        res_fault_reg <= (mode == MODE_POP) & ring_empty;
                        if (take_now)
                        begin
                            state_reg <= ST_TAKE;
                        end
                        else if (read_hit)
                        begin
                            state_reg <= ST_READ;
                        end
                        else if (mode == MODE_PUSH)
                        begin
                            state_reg <= ST_PUSH;
                        end
                        else
                        begin
                            state_reg <= ST_STATUS;
                        end
                    end
                end

                ST_TAKE:
                begin
                    oldest_reg <= oldest_inc;
                    count_reg  <= count_reg - CNT_W'(1);
                    sum_reg    <= sum_reg - rd_ext;
                    if (mode_reg == MODE_PUSH)
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else
                    begin
                        res_data_reg <= rd_data_reg;
                        state_reg    <= ST_STATUS;
                    end
                end

                ST_PUSH:
                begin
                    newest_reg <= newest_inc;
                    count_reg  <= count_reg + CNT_W'(1);
                    sum_reg    <= sum_reg + sample_ext;
                    state_reg  <= ST_STATUS;
                end

                ST_READ:
                begin
                    res_data_reg <= rd_data_reg;
                    state_reg    <= ST_STATUS;
                end

                ST_STATUS:
                begin
                    rem_reg <= '0;
                    quo_reg <= '0;
                    neg_reg <= sum_reg[SUM_W-1];
                    if (!ring_empty)
                    begin
                        dvd_reg   <= sum_mag;
                        step_reg  <= STEP_W'(SUM_W - 1);
                        state_reg <= ST_DIV_AVG;
                    end
                    else
                    begin
                        res_avg_reg <= '0;
                        dvd_reg     <= SUM_W'(pct_num) << (SUM_W - PNUM_W);
                        step_reg    <= STEP_W'(PNUM_W - 1);
                        state_reg   <= ST_DIV_PCT;
                    end
                end

                ST_DIV_AVG:
                begin
                    if (step_reg == '0)
                    begin
                        res_avg_reg <= avg_signed;
                        dvd_reg     <= SUM_W'(pct_num) << (SUM_W - PNUM_W);
                        rem_reg     <= '0;
                        quo_reg     <= '0;
                        step_reg    <= STEP_W'(PNUM_W - 1);
                        state_reg   <= ST_DIV_PCT;
                    end
                    else
                    begin
                        dvd_reg  <= dvd_reg << 1;
                        rem_reg  <= rem_new;
                        quo_reg  <= quo_new;
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end

                ST_DIV_PCT:
                begin
                    dvd_reg <= dvd_reg << 1;
                    rem_reg <= rem_new;
                    quo_reg <= quo_new;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end

                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign data         = out_data_reg;
    assign average      = out_avg_reg;
    assign fill_count   = out_fill_reg;
    assign used_percent = out_pct_reg;
    assign is_full      = out_full_reg;
    assign is_empty     = out_empty_reg;
    assign fault        = out_fault_reg;

endmodule

`default_nettype wire

@@ src/orba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "overwrite_ring_buffer_with_average_defines.svh"

module orba_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  out_valid,
    input wire                                  out_stall,
    input wire  [orba_pkg::SAMPLE_W-1:0]        data,
    input wire  [orba_pkg::AVG_W-1:0]           average,
    input wire  [orba_pkg::FILL_W-1:0]          fill_count,
    input wire  [orba_pkg::PCT_W-1:0]           used_percent,
    input wire                                  is_full,
    input wire                                  is_empty,
    input wire                                  fault
);

    import orba_pkg::*;

    `ORBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data) && $stable(fill_count), "stalled result changed")
    `ORBA_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (fill_count == '0), "empty flag disagrees with fill count")
    `ORBA_ASSERT_NOW(a_empty_status, out_valid && is_empty, !is_full && average == '0 && used_percent == '0, "empty ring reports nonzero status")
    `ORBA_ASSERT_NOW(a_full_percent, out_valid && is_full, used_percent == PCT_W'(PERCENT_SCALE), "full ring not at full percent")
    `ORBA_ASSERT_NOW(a_fault_empty, out_valid && fault, is_empty && data == '0, "fault without empty ring")

endmodule

bind overwrite_ring_buffer_with_average orba_checker u_orba_checker (.*);

`default_nettype wire
